[hw/rtl/dkec_pkg.sv]
package dkec_pkg;

    // Widths of the byte position, the slice end positions, the length value and the output code
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned POS_W   = 33;
    localparam int unsigned LENV_W  = 32;
    localparam int unsigned CODE_OW = 64;

    // Tag bytes of interest
    localparam logic [7:0] TAG_TICKET     = 8'h6b;
    localparam logic [7:0] TAG_ERROR      = 8'h7e;
    localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
    localparam logic [7:0] TAG_CODE_FIELD = 8'ha6;
    localparam logic [7:0] TAG_INTEGER    = 8'h02;

    // Reply classification
    localparam logic [1:0] KIND_INVALID = 2'd0;
    localparam logic [1:0] KIND_TICKET  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Parse phases: W = wrapper, S = sequence, F = field, I = integer
    typedef enum logic [3:0] {
        PH_FIRST  = 4'd0,
        PH_W_LEN  = 4'd1,
        PH_W_LENX = 4'd2,
        PH_S_TAG  = 4'd3,
        PH_S_LEN  = 4'd4,
        PH_S_LENX = 4'd5,
        PH_F_TAG  = 4'd6,
        PH_F_LEN  = 4'd7,
        PH_F_LENX = 4'd8,
        PH_F_SKIP = 4'd9,
        PH_I_TAG  = 4'd10,
        PH_I_LEN  = 4'd11,
        PH_I_LENX = 4'd12,
        PH_I_BODY = 4'd13,
        PH_DONE   = 4'd14,
        PH_IDLE   = 4'd15
    } t_phase;

    // One result item
    typedef struct packed {
        logic               code_found;
        logic [1:0]         reply_kind;
        logic [CODE_OW-1:0] err_code;
    } t_result;

endpackage

[hw/rtl/der_krb_error_code_extractor_top.sv]
// Error-code extractor for DER-encoded Kerberos-style replies. Message bytes
// arrive on the slave stream, tlast marking the final byte; one result
// transfer follows each message, offered from the cycle after its last byte is taken.
// The result gives the reply kind (invalid, ticket reply on first byte 0x6b,
// error reply on 0x7e), whether the error code inside context field [6]
// was found, and that code sign-extended to 64 bits (-1 when not found).
// Throughput is one byte per clock: the whole parse state is updated by a
// single registered step per byte. The input stalls only while a finished
// result sits in the output register and the downstream side is not ready.
module der_krb_error_code_extractor_top #(
    parameter int unsigned MAX_LENGTH_OCTETS = 4,
    parameter int unsigned MAX_INTEGER_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] err_code
    output logic [2:0]  m_axis_tuser    // [1:0] reply_kind, [2] code_found
);
    import dkec_pkg::*;

    logic    in_xfer;
    t_result parse_result;
    logic    r_out_valid, n_out_valid;
    t_result r_out;

    // Output register frees itself when its transfer completes
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    dkec_parser #(
        .MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS),
        .MAX_INTEGER_BYTES (MAX_INTEGER_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_xfer),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_result (parse_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_xfer && s_axis_tlast) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (in_xfer && s_axis_tlast) begin
            r_out <= parse_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.err_code;
    assign m_axis_tuser  = {r_out.code_found, r_out.reply_kind};

endmodule

[hw/rtl/dkec_parser.sv]
module dkec_parser #(
    parameter int unsigned MAX_LENGTH_OCTETS = 4,
    parameter int unsigned MAX_INTEGER_BYTES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output dkec_pkg::t_result o_result
);
    import dkec_pkg::*;

    localparam int unsigned LEN_W  = 8 * MAX_LENGTH_OCTETS;
    localparam int unsigned OCT_W  = $clog2(MAX_LENGTH_OCTETS + 1);
    localparam int unsigned CODE_W = 8 * MAX_INTEGER_BYTES;

    // Parse state
    t_phase              r_phase,      n_phase,  s_phase;
    logic [CNT_W-1:0]    r_count,      n_count;
    logic [7:0]          r_tag,        n_tag;
    logic [7:0]          r_first_tag,  n_first_tag;
    logic [LEN_W-1:0]    r_len_acc,    n_len_acc;
    logic [OCT_W-1:0]    r_oct_left,   n_oct_left;
    logic [POS_W-1:0]    r_wrap_end,   n_wrap_end;
    logic [POS_W-1:0]    r_seq_end,    n_seq_end;
    logic [POS_W-1:0]    r_field_end,  n_field_end;
    logic [POS_W-1:0]    r_int_end,    n_int_end;
    logic [CODE_W-1:0]   r_code,       n_code;

    // Shared per-byte terms
    logic [POS_W-1:0]    p_ext;
    logic [POS_W-1:0]    p1;
    logic                at_max;
    logic                lvl0;
    logic [POS_W-1:0]    encl_end;
    logic [6:0]          octets;
    logic [LEN_W-1:0]    acc_shift;
    logic [OCT_W-1:0]    oct_dec;
    logic                len_done;
    logic [LENV_W-1:0]   len_val;
    logic [POS_W-1:0]    new_end;
    logic [POS_W-1:0]    total;
    logic [1:0]          kind;
    logic                found;

    assign p_ext     = {1'b0, r_count};
    assign p1        = p_ext + POS_W'(1);
    assign at_max    = &r_count;
    assign lvl0      = (r_phase == PH_W_LEN) || (r_phase == PH_W_LENX);
    assign octets    = i_byte[6:0];
    assign acc_shift = LEN_W'({r_len_acc, i_byte});
    assign oct_dec   = (r_oct_left != '0) ? r_oct_left - OCT_W'(1) : r_oct_left;
    assign total     = p1;

    // End of the slice that encloses the length being read
    always_comb begin
        unique case (r_phase)
            PH_S_LEN, PH_S_LENX: encl_end = r_wrap_end;
            PH_F_LEN, PH_F_LENX: encl_end = r_seq_end;
            default:             encl_end = r_field_end;
        endcase
    end

    // Next state: one byte per transfer
    always_comb begin
        s_phase     = r_phase;
        n_tag       = r_tag;
        n_first_tag = r_first_tag;
        n_len_acc   = r_len_acc;
        n_oct_left  = r_oct_left;
        n_wrap_end  = r_wrap_end;
        n_seq_end   = r_seq_end;
        n_field_end = r_field_end;
        n_int_end   = r_int_end;
        n_code      = r_code;
        len_done    = 1'b0;
        len_val     = LENV_W'(i_byte);
        new_end     = '0;

        if (i_valid) begin
            priority if (r_phase == PH_FIRST) begin
                n_first_tag = i_byte;
                n_tag       = i_byte;
                s_phase     = (i_byte == TAG_ERROR) ? PH_W_LEN : PH_IDLE;
            end else if (at_max && (r_phase != PH_DONE) && (r_phase != PH_IDLE)) begin
                // count saturated mid-parse
                s_phase = PH_IDLE;
            end else begin
                unique case (r_phase)
                    PH_W_LEN, PH_S_LEN, PH_F_LEN, PH_I_LEN: begin
                        if (!lvl0 && (p_ext >= encl_end)) begin
                            s_phase = PH_IDLE;
                        end else if (i_byte[7]) begin
                            // long form: count of length octets
                            if ((octets == '0) || (octets > 7'(MAX_LENGTH_OCTETS)) ||
                                (!lvl0 && (p1 + POS_W'(octets) > encl_end))) begin
                                s_phase = PH_IDLE;
                            end else begin
                                n_len_acc  = '0;
                                n_oct_left = OCT_W'(octets);
                                unique case (r_phase)
                                    PH_W_LEN: s_phase = PH_W_LENX;
                                    PH_S_LEN: s_phase = PH_S_LENX;
                                    PH_F_LEN: s_phase = PH_F_LENX;
                                    default:  s_phase = PH_I_LENX;
                                endcase
                            end
                        end else begin
                            len_done = 1'b1;
                        end
                    end
                    PH_W_LENX, PH_S_LENX, PH_F_LENX, PH_I_LENX: begin
                        n_len_acc  = acc_shift;
                        n_oct_left = oct_dec;
                        len_val    = LENV_W'(acc_shift);
                        len_done   = (oct_dec == '0);
                    end
                    PH_S_TAG: begin
                        if ((p_ext >= r_wrap_end) || (i_byte != TAG_SEQUENCE)) begin
                            s_phase = PH_IDLE;
                        end else begin
                            n_tag   = i_byte;
                            s_phase = PH_S_LEN;
                        end
                    end
                    PH_F_TAG: begin
                        if (p_ext >= r_seq_end) begin
                            s_phase = PH_IDLE;
                        end else begin
                            n_tag   = i_byte;
                            s_phase = PH_F_LEN;
                        end
                    end
                    PH_F_SKIP: begin
                        if (p1 >= r_field_end) begin
                            s_phase = (p1 >= r_seq_end) ? PH_IDLE : PH_F_TAG;
                        end
                    end
                    PH_I_TAG: begin
                        if ((p_ext >= r_field_end) || (i_byte != TAG_INTEGER)) begin
                            s_phase = PH_IDLE;
                        end else begin
                            n_tag   = i_byte;
                            s_phase = PH_I_LEN;
                        end
                    end
                    PH_I_BODY: begin
                        // first content byte carries the sign
                        if (p_ext + POS_W'(r_len_acc) == r_int_end) begin
                            n_code = CODE_W'($signed(i_byte));
                        end else begin
                            n_code = CODE_W'({r_code, i_byte});
                        end
                        if (p1 >= r_int_end) begin
                            s_phase = PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // A complete length opens the next slice
            new_end = p1 + POS_W'(len_val);
            if (len_done) begin
                if (!lvl0 && (new_end > encl_end)) begin
                    s_phase = PH_IDLE;
                end else begin
                    unique case (r_phase)
                        PH_W_LEN, PH_W_LENX: begin
                            n_wrap_end = new_end;
                            s_phase    = PH_S_TAG;
                        end
                        PH_S_LEN, PH_S_LENX: begin
                            n_seq_end = new_end;
                            s_phase   = (len_val == '0) ? PH_IDLE : PH_F_TAG;
                        end
                        PH_F_LEN, PH_F_LENX: begin
                            n_field_end = new_end;
                            priority if (r_tag == TAG_CODE_FIELD) begin
                                s_phase = (len_val == '0) ? PH_IDLE : PH_I_TAG;
                            end else if (len_val == '0) begin
                                s_phase = (new_end >= r_seq_end) ? PH_IDLE : PH_F_TAG;
                            end else begin
                                s_phase = PH_F_SKIP;
                            end
                        end
                        default: begin
                            n_int_end = new_end;
                            if ((len_val == '0) || (len_val > LENV_W'(MAX_INTEGER_BYTES))) begin
                                s_phase = PH_IDLE;
                            end else begin
                                n_len_acc = LEN_W'(len_val);
                                s_phase   = PH_I_BODY;
                            end
                        end
                    endcase
                end
            end
        end

        // Control state returns to its start after the last byte
        n_phase = r_phase;
        n_count = r_count;
        if (i_valid) begin
            n_phase = i_last ? PH_FIRST : s_phase;
            n_count = i_last ? '0 : (at_max ? r_count : r_count + CNT_W'(1));
        end
    end

    // Result of the message that ends with this byte
    always_comb begin
        priority if (total < POS_W'(2)) begin
            kind = KIND_INVALID;
        end else if (n_first_tag == TAG_TICKET) begin
            kind = KIND_TICKET;
        end else if (n_first_tag == TAG_ERROR) begin
            kind = KIND_ERROR;
        end else begin
            kind = KIND_INVALID;
        end
        found = (kind == KIND_ERROR) && (s_phase == PH_DONE) && (n_wrap_end <= total);
        o_result.reply_kind = kind;
        o_result.code_found = found;
        o_result.err_code   = found ? CODE_OW'($signed(n_code)) : '1;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Data registers, each written before it is read
    always_ff @(posedge i_clk) begin
        r_tag       <= n_tag;
        r_first_tag <= n_first_tag;
        r_len_acc   <= n_len_acc;
        r_oct_left  <= n_oct_left;
        r_wrap_end  <= n_wrap_end;
        r_seq_end   <= n_seq_end;
        r_field_end <= n_field_end;
        r_int_end   <= n_int_end;
        r_code      <= n_code;
    end

endmodule
